### rtl/core/cdfis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfis_pkg
// Shared widths, codes and types of the tabulated CDF inverse sampler.
// ----------------------------------------------------------------------------
package cdfis_pkg;

   localparam int unsigned DENSITY_W   = 32;  // unsigned Q8.24
   localparam int unsigned STEP_W      = 32;  // unsigned Q8.24
   localparam int unsigned U_W         = 32;  // unsigned Q8.24
   localparam int unsigned POS_W       = 48;  // signed Q23.24
   localparam int unsigned ACC_W       = 40;  // unsigned Q16.24
   localparam int unsigned FRAC_W      = 24;
   localparam int unsigned BIN_IDX_W   = 10;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 48;

   localparam logic [STEP_W-1:0] STEP_RESET = 32'h0100_0000;

   // Item kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_START = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_WIDTH  = 2'd1;

   typedef struct packed {
      logic mul_en;
      logic empty;
   } pos_ctrl_type;

endpackage

### rtl/core/cdfis_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfis_req_if / cdfis_rsp_if
// Valid/ready channels for sampler requests and sampler results.
// ----------------------------------------------------------------------------
interface cdfis_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] density;
   logic        last_sample;
   logic [31:0] u_value;
   logic signed [47:0] offset;
   logic        use_start;

   modport source (output valid, req_type, density, last_sample, u_value, offset, use_start,
                   input ready);
   modport sink   (input valid, req_type, density, last_sample, u_value, offset, use_start,
                   output ready);
endinterface

interface cdfis_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [47:0] position;
   logic [9:0]  bin_index;
   logic        table_empty;

   modport source (output valid, position, bin_index, table_empty, input ready);
   modport sink   (input valid, position, bin_index, table_empty, output ready);
endinterface

### rtl/core/cdfis_cum_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfis_cum_mem
// Cumulative table store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cdfis_cum_mem #(
   parameter int unsigned DEPTH  = 1024,
   parameter int unsigned ADDR_W = 10
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [cdfis_pkg::ACC_W-1:0]   wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [cdfis_pkg::ACC_W-1:0]   rd_data
);

   logic [cdfis_pkg::ACC_W-1:0] mem_ff [DEPTH];
   logic [cdfis_pkg::ACC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cdfis_pos_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfis_pos_calc
// Position unit: registered step times index, then saturating origin add.
// ----------------------------------------------------------------------------
module cdfis_pos_calc #(
   parameter int unsigned IDX_W = 10
) (
   input  logic                                clock,
   input  cdfis_pkg::pos_ctrl_type             ctrl,
   input  logic [cdfis_pkg::STEP_W-1:0]        step_width,
   input  logic [IDX_W-1:0]                    idx,
   input  logic signed [cdfis_pkg::POS_W-1:0]  origin,
   output logic signed [cdfis_pkg::POS_W-1:0]  position
);

   localparam int unsigned PROD_W = cdfis_pkg::STEP_W + IDX_W;
   localparam int unsigned EXT_W  =
      ((PROD_W > cdfis_pkg::POS_W) ? PROD_W : cdfis_pkg::POS_W) + 2;
   localparam int unsigned HI_W   = EXT_W - cdfis_pkg::POS_W + 1;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [EXT_W-1:0]  sum;
   logic [HI_W-1:0]   sum_hi;

   assign prod_in = PROD_W'(step_width) * PROD_W'(idx);

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign sum    = {{(EXT_W-cdfis_pkg::POS_W){origin[cdfis_pkg::POS_W-1]}}, origin}
                 + {{(EXT_W-PROD_W){1'b0}}, prod_ff};
   assign sum_hi = sum[EXT_W-1:cdfis_pkg::POS_W-1];

   // The result fits when every bit above the sign bit of the 48-bit range
   // agrees with it; otherwise clamp towards the true sign.
   always_comb begin
      if (ctrl.empty) begin
         position = '0;
      end else if ((sum_hi == '0) || (sum_hi == '1)) begin
         position = sum[cdfis_pkg::POS_W-1:0];
      end else if (sum[EXT_W-1]) begin
         position = {1'b1, {(cdfis_pkg::POS_W-1){1'b0}}};
      end else begin
         position = {1'b0, {(cdfis_pkg::POS_W-1){1'b1}}};
      end
   end

endmodule

### rtl/core/cdf_inverse_sampler_core.sv
`timescale 1ns / 1ps
// Flow: a load item is accepted, then its scaled density is added and written; a query is
// accepted with the first read, searched on the memory read port, then multiplied and
// origin-added, and its result is registered at the output.
// Throughput: one item at a time; an empty-table query skips the search; a finished query
// holds its last stage while the previous result still waits at the output.
// Reset (synchronous) clears control state, sum, pointers and range start, sets the step width to 1.0, not the memory.
// ----------------------------------------------------------------------------
// cdf_inverse_sampler_core
// Tabulated density sampler: builds a cumulative table and inverts it by search.
// ----------------------------------------------------------------------------
module cdf_inverse_sampler_core #(
   parameter int unsigned MAX_BINS = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   cdfis_req_if.sink                              req_chan,
   cdfis_rsp_if.source                            rsp_chan,
   input  logic                                   csr_we,
   input  logic [cdfis_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cdfis_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int unsigned ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int unsigned PTR_W  = $clog2(MAX_BINS + 1);
   localparam int unsigned ACC_W  = cdfis_pkg::ACC_W;
   localparam int unsigned MPY_W  = cdfis_pkg::DENSITY_W + cdfis_pkg::STEP_W;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_LOAD_ADD = 5'b00010,
      ST_SEARCH   = 5'b00100,
      ST_POS_MUL  = 5'b01000,
      ST_POS_ADD  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic signed [cdfis_pkg::POS_W-1:0] range_start_ff, range_start_in;
   logic [cdfis_pkg::STEP_W-1:0]       step_width_ff, step_width_in;
   logic [ACC_W-1:0]                   sum_ff, sum_in;
   logic [PTR_W-1:0]                   ptr_ff, ptr_in;
   logic [PTR_W-1:0]                   size_ff, size_in;
   logic                               closed_ff, closed_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic [MPY_W-1:0]                   lprod_ff, lprod_in;
   logic                               last_ff, last_in;
   logic [cdfis_pkg::U_W-1:0]          u_ff, u_in;
   logic signed [cdfis_pkg::POS_W-1:0] origin_ff, origin_in;
   logic                               empty_ff, empty_in;
   logic [ADDR_W-1:0]                  lo_ff, lo_in;
   logic [ADDR_W-1:0]                  hi_ff, hi_in;
   logic [ADDR_W-1:0]                  mid_ff, mid_in;
   logic signed [cdfis_pkg::POS_W-1:0] rsp_position_ff, rsp_position_in;
   logic [cdfis_pkg::BIN_IDX_W-1:0]    rsp_bin_ff, rsp_bin_in;
   logic                               rsp_empty_ff, rsp_empty_in;

   logic                      accept;
   logic                      out_free;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [ACC_W-1:0]          wr_data;
   logic [ADDR_W-1:0]         rd_addr;
   logic [ACC_W-1:0]          rd_data;
   logic [ACC_W-1:0]          base_sum;
   logic [PTR_W-1:0]          base_ptr;
   logic [ACC_W:0]            sum_wide;
   logic [ACC_W-1:0]          sum_sat;
   logic                      table_room;
   logic                      entry_ge;
   logic [ADDR_W-1:0]         step_lo;
   logic [ADDR_W-1:0]         step_hi;
   logic [ADDR_W-1:0]         size_top;
   logic [ADDR_W+cdfis_pkg::BIN_IDX_W-1:0] idx_ext;
   logic signed [cdfis_pkg::POS_W-1:0]     position;
   cdfis_pkg::pos_ctrl_type   pos_ctrl;

   assign accept        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_chan.ready;

   // A fresh load after a closed table starts from an empty table.
   assign base_sum   = closed_ff ? '0 : sum_ff;
   assign base_ptr   = closed_ff ? '0 : ptr_ff;
   assign table_room = (base_ptr < PTR_W'(MAX_BINS));
   assign sum_wide   = {1'b0, base_sum} + {1'b0, lprod_ff[MPY_W-1:cdfis_pkg::FRAC_W]};
   assign sum_sat    = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];

   assign wr_en   = (state_ff == ST_LOAD_ADD) && table_room;
   assign wr_addr = base_ptr[ADDR_W-1:0];
   assign wr_data = sum_sat;

   assign size_top = ADDR_W'(size_ff - PTR_W'(1));
   assign entry_ge = (rd_data >= ACC_W'(u_ff));
   assign step_lo  = entry_ge ? lo_ff : (mid_ff + ADDR_W'(1));
   assign step_hi  = entry_ge ? mid_ff : hi_ff;

   assign pos_ctrl.mul_en = (state_ff == ST_POS_MUL);
   assign pos_ctrl.empty  = empty_ff;
   assign idx_ext         = (ADDR_W + cdfis_pkg::BIN_IDX_W)'(lo_ff);

   always_comb begin
      state_in        = state_ff;
      range_start_in  = range_start_ff;
      step_width_in   = step_width_ff;
      sum_in          = sum_ff;
      ptr_in          = ptr_ff;
      size_in         = size_ff;
      closed_in       = closed_ff;
      rsp_valid_in    = rsp_valid_ff;
      lprod_in        = lprod_ff;
      last_in         = last_ff;
      u_in            = u_ff;
      origin_in       = origin_ff;
      empty_in        = empty_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      rsp_position_in = rsp_position_ff;
      rsp_bin_in      = rsp_bin_ff;
      rsp_empty_in    = rsp_empty_ff;
      rd_addr         = mid_ff;

      if (csr_we) begin
         case (csr_index)
            cdfis_pkg::CSR_RANGE_START: range_start_in = csr_wdata[cdfis_pkg::POS_W-1:0];
            cdfis_pkg::CSR_STEP_WIDTH:  step_width_in  = csr_wdata[cdfis_pkg::STEP_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.req_type == cdfis_pkg::REQ_LOAD) begin
                  lprod_in = MPY_W'(req_chan.density) * MPY_W'(step_width_ff);
                  last_in  = req_chan.last_sample;
                  state_in = ST_LOAD_ADD;
               end else begin
                  u_in      = req_chan.u_value;
                  origin_in = req_chan.use_start ? range_start_ff : req_chan.offset;
                  lo_in     = '0;
                  hi_in     = size_top;
                  mid_in    = size_top >> 1;
                  rd_addr   = size_top >> 1;
                  if (!closed_ff || (size_ff == '0)) begin
                     empty_in = 1'b1;
                     state_in = ST_POS_MUL;
                  end else if (size_top == '0) begin
                     empty_in = 1'b0;
                     state_in = ST_POS_MUL;
                  end else begin
                     empty_in = 1'b0;
                     state_in = ST_SEARCH;
                  end
               end
            end
         end
         ST_LOAD_ADD: begin
            sum_in    = base_sum;
            ptr_in    = base_ptr;
            size_in   = closed_ff ? '0 : size_ff;
            closed_in = 1'b0;
            if (table_room) begin
               sum_in = sum_sat;
               ptr_in = base_ptr + PTR_W'(1);
            end
            if (last_ff) begin
               size_in   = table_room ? (base_ptr + PTR_W'(1)) : base_ptr;
               closed_in = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            // The entry at mid arrived this cycle; narrow and read the next mid.
            lo_in   = step_lo;
            hi_in   = step_hi;
            mid_in  = step_lo + ((step_hi - step_lo) >> 1);
            rd_addr = step_lo + ((step_hi - step_lo) >> 1);
            if (step_lo == step_hi) begin
               state_in = ST_POS_MUL;
            end
         end
         ST_POS_MUL: begin
            state_in = ST_POS_ADD;
         end
         ST_POS_ADD: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = position;
               rsp_bin_in      = empty_ff ? '0 : idx_ext[cdfis_pkg::BIN_IDX_W-1:0];
               rsp_empty_in    = empty_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         range_start_ff <= '0;
         step_width_ff  <= cdfis_pkg::STEP_RESET;
         sum_ff         <= '0;
         ptr_ff         <= '0;
         size_ff        <= '0;
         closed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         range_start_ff <= range_start_in;
         step_width_ff  <= step_width_in;
         sum_ff         <= sum_in;
         ptr_ff         <= ptr_in;
         size_ff        <= size_in;
         closed_ff      <= closed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lprod_ff        <= lprod_in;
      last_ff         <= last_in;
      u_ff            <= u_in;
      origin_ff       <= origin_in;
      empty_ff        <= empty_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      rsp_position_ff <= rsp_position_in;
      rsp_bin_ff      <= rsp_bin_in;
      rsp_empty_ff    <= rsp_empty_in;
   end

   cdfis_cum_mem #(
      .DEPTH  (MAX_BINS),
      .ADDR_W (ADDR_W)
   ) u_cum_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cdfis_pos_calc #(
      .IDX_W (ADDR_W)
   ) u_pos_calc (
      .clock      (clock),
      .ctrl       (pos_ctrl),
      .step_width (step_width_ff),
      .idx        (lo_ff),
      .origin     (origin_ff),
      .position   (position)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.position    = rsp_position_ff;
   assign rsp_chan.bin_index   = rsp_bin_ff;
   assign rsp_chan.table_empty = rsp_empty_ff;

endmodule
